>>> src/lpbe_pkg.sv
// Shared types and constants for the LED pixel bit encoder.
package lpbe_pkg;

   // Brightness saturation and divide-by-100 via reciprocal (x * 5243) >> 19
   localparam logic [6:0]  PCT_FULL    = 7'd100;
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;

   // Configuration register reset values
   localparam logic [7:0] DUTY_ONE_RESET  = 8'd38;
   localparam logic [7:0] DUTY_ZERO_RESET = 8'd19;

   // Register indexes (byte address 4*i, index is paddr[2])
   typedef enum logic {
      REG_DUTY_ONE  = 1'b0,
      REG_DUTY_ZERO = 1'b1
   } reg_index_type;

   // Down-counter value loaded for the final wire bit position
   localparam logic [4:0] CNT_RGB_LAST  = 5'd23;
   localparam logic [4:0] CNT_RGBW_LAST = 5'd31;

   // Scaled pixel handed from the color pipeline to the serializer
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       rgbw;
   } pixel_type;

endpackage

>>> src/lpbe_if.sv
// Request and response channel interfaces for the LED pixel bit encoder.
interface lpbe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [6:0] level_pct;
   logic       chip_is_rgbw;

   modport source (output valid, red, green, blue, level_pct, chip_is_rgbw,
                   input ready);
   modport sink   (input valid, red, green, blue, level_pct, chip_is_rgbw,
                   output ready);
endinterface

interface lpbe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] duty_code;
   logic       last_code;

   modport source (output valid, duty_code, last_code, input ready);
   modport sink   (input valid, duty_code, last_code, output ready);
endinterface

>>> src/led_pixel_bit_encoder.sv
// Top level: color pipeline, white extraction, bit serializer and CSR port.
//
//   channel   direction  transfer            payload
//   req_chan  in         valid && ready      red, green, blue, level_pct, chip_is_rgbw
//   rsp_chan  out        valid && ready      duty_code, last_code
//   csr       in/out     psel&penable&pwrite duty_for_one @0x0, duty_for_zero @0x4
//
// One LED takes 24 (RGB) or 32 (RGBW) duty codes, set by the serializer that moves one
// duty code per response transfer; the first code is valid once the request has passed
// the capture, multiply and divide stages and been loaded into the serializer.
// Reset clears all valid bits and loads duty_for_one = 38, duty_for_zero = 19.
// While rsp_chan.ready is low the serializer holds; up to three further requests
// queue in the color pipeline before req_chan.ready drops.
module led_pixel_bit_encoder
   import lpbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   lpbe_req_if.sink    req_chan,
   lpbe_rsp_if.source  rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Configuration registers
   logic [7:0] duty_one_ff, duty_zero_ff;
   logic       csr_write;
   reg_index_type csr_index;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_one_ff  <= DUTY_ONE_RESET;
         duty_zero_ff <= DUTY_ZERO_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_DUTY_ONE:  duty_one_ff  <= pwdata[7:0];
            REG_DUTY_ZERO: duty_zero_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_DUTY_ONE:  prdata = {24'd0, duty_one_ff};
         REG_DUTY_ZERO: prdata = {24'd0, duty_zero_ff};
         default:       prdata = 32'd0;
      endcase
   end

   // Color pipeline
   logic      pix_valid;
   pixel_type pix;
   logic      load;

   lpbe_color_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .pix_valid (pix_valid),
      .pix       (pix),
      .pix_take  (load)
   );

   // White extraction for RGBW chips
   logic [7:0] min_rg, white;
   logic [31:0] bits_load;

   always_comb begin
      min_rg    = (pix.red < pix.green) ? pix.red : pix.green;
      white     = pix.rgbw ? ((pix.blue < min_rg) ? pix.blue : min_rg) : 8'd0;
      bits_load = {8'(pix.green - white), 8'(pix.red - white),
                   8'(pix.blue - white), white};
   end

   // Serializer: MSB of the shift register is the current wire bit
   logic        busy_ff, busy_in;
   logic [31:0] shift_ff, shift_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        rsp_done;

   assign rsp_done = busy_ff && rsp_chan.ready;
   assign load     = pix_valid && (!busy_ff || (rsp_chan.ready && cnt_ff == 5'd0));

   always_comb begin
      busy_in  = busy_ff;
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         busy_in  = 1'b1;
         shift_in = bits_load;
         cnt_in   = pix.rgbw ? CNT_RGBW_LAST : CNT_RGB_LAST;
      end else if (rsp_done) begin
         busy_in  = (cnt_ff != 5'd0);
         shift_in = {shift_ff[30:0], 1'b0};
         cnt_in   = cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      cnt_ff   <= cnt_in;
   end

   assign rsp_chan.valid     = busy_ff;
   assign rsp_chan.duty_code = shift_ff[31] ? duty_one_ff : duty_zero_ff;
   assign rsp_chan.last_code = (cnt_ff == 5'd0);

   // Assertions
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (!busy_ff || (rsp_chan.ready && cnt_ff == 5'd0)))
      else $error("serializer loaded while a code sequence is in flight");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      load |=> (cnt_ff == CNT_RGB_LAST || cnt_ff == CNT_RGBW_LAST))
      else $error("bad code count after load");

   a_white_removed: assert property (@(posedge clock) disable iff (reset)
      (load && pix.rgbw) |=>
         (shift_ff[31:24] == 8'd0 || shift_ff[23:16] == 8'd0 || shift_ff[15:8] == 8'd0))
      else $error("white not subtracted from the smallest channel");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last_code && !load) |=> !rsp_chan.valid)
      else $error("response valid after last code with nothing loaded");

endmodule

>>> src/lpbe_color_pipe.sv
// Three-stage color pipeline: input capture, brightness multiply, divide by 100.
module lpbe_color_pipe
   import lpbe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   lpbe_req_if.sink  req_chan,
   output logic      pix_valid,
   output pixel_type pix,
   input  logic      pix_take
);

   // Stage 1: captured request, brightness saturated
   logic       v1_ff, v1_in;
   logic [7:0] r1_ff, g1_ff, b1_ff;
   logic [6:0] pct1_ff;
   logic       w1_ff;

   // Stage 2: channel times percent
   logic        v2_ff, v2_in;
   logic [14:0] r2_ff, g2_ff, b2_ff;
   logic        w2_ff;

   // Stage 3: scaled channels
   logic      v3_ff, v3_in;
   pixel_type p3_ff, p3_in;

   logic s1_open, s2_open, s3_open;
   logic [6:0] pct_sat;
   logic [14:0] r2_in, g2_in, b2_in;
   logic [27:0] rq, gq, bq;

   // Stage occupancy: a stage opens when empty or when its content moves on
   always_comb begin
      s3_open = !v3_ff || pix_take;
      s2_open = !v2_ff || s3_open;
      s1_open = !v1_ff || s2_open;
      v1_in   = s1_open ? req_chan.valid : v1_ff;
      v2_in   = s2_open ? v1_ff : v2_ff;
      v3_in   = s3_open ? v2_ff : v3_ff;
   end

   assign req_chan.ready = s1_open;

   assign pct_sat = (req_chan.level_pct > PCT_FULL) ? PCT_FULL
                                                    : req_chan.level_pct;

   // Brightness multiply
   always_comb begin
      r2_in = 15'(r1_ff) * 15'(pct1_ff);
      g2_in = 15'(g1_ff) * 15'(pct1_ff);
      b2_in = 15'(b1_ff) * 15'(pct1_ff);
   end

   // Divide by 100 through the reciprocal, exact for products up to 25500
   always_comb begin
      rq = 28'(r2_ff) * 28'(RECIP_100);
      gq = 28'(g2_ff) * 28'(RECIP_100);
      bq = 28'(b2_ff) * 28'(RECIP_100);
      p3_in.red   = rq[RECIP_SHIFT +: 8];
      p3_in.green = gq[RECIP_SHIFT +: 8];
      p3_in.blue  = bq[RECIP_SHIFT +: 8];
      p3_in.rgbw  = w2_ff;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (s1_open && req_chan.valid) begin
         r1_ff   <= req_chan.red;
         g1_ff   <= req_chan.green;
         b1_ff   <= req_chan.blue;
         pct1_ff <= pct_sat;
         w1_ff   <= req_chan.chip_is_rgbw;
      end
      if (s2_open && v1_ff) begin
         r2_ff <= r2_in;
         g2_ff <= g2_in;
         b2_ff <= b2_in;
         w2_ff <= w1_ff;
      end
      if (s3_open && v2_ff) begin
         p3_ff <= p3_in;
      end
   end

   assign pix_valid = v3_ff;
   assign pix       = p3_ff;

endmodule
